// File: rtl/point_to_morton_code_top_defines.svh
// Assertion macros shared by the Morton code block.
`ifndef POINT_TO_MORTON_CODE_TOP_DEFINES_SVH
`define POINT_TO_MORTON_CODE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define MC_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("morton code check failed");
// Condition that implies a consequence in the next cycle.
`define MC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("morton code check failed");
`else
`define MC_ASSERT(lbl, cond)
`define MC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/mc_pkg.sv
// ----------------------------------------------------------------------------
// mc_pkg
// Shared constants, register codes and helpers of the Morton code block.
// ----------------------------------------------------------------------------
package mc_pkg;

    localparam int DEPTH   = 21;
    localparam int STAGES  = DEPTH + 1;
    localparam int COORD_W = 32;
    localparam int CODE_W  = 3 * DEPTH;
    localparam logic [DEPTH-1:0] CELL_MAX = {DEPTH{1'b1}};

    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_EXTENT_X = 3'd3,
        CFG_EXTENT_Y = 3'd4,
        CFG_EXTENT_Z = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic load;
    } mrg_ctrl_t;

    // x bit highest of each triple, then y, then z
    function automatic logic [CODE_W-1:0] interleave(
        input logic [DEPTH-1:0] cx,
        input logic [DEPTH-1:0] cy,
        input logic [DEPTH-1:0] cz
    );
        logic [CODE_W-1:0] code;
        code = '0;
        for (int b = 0; b < DEPTH; b++)
        begin
            code[3*b+2] = cx[b];
            code[3*b+1] = cy[b];
            code[3*b]   = cz[b];
        end
        return code;
    endfunction

endpackage

// File: rtl/point_to_morton_code_top.sv
// ----------------------------------------------------------------------------
// point_to_morton_code_top
// Maps a 3D point to grid cells over a configured box and their Morton code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one point per item.
//   Output channel (out_valid / out_stall) returns the Morton code and the
//   three clamped cells, one item per input item, in order.
//   Config channel (cfg_valid / cfg_ready) writes origin and extent
//   registers by index; cfg_ready is always high, unknown indexes are
//   dropped. Write only while the block is empty.
// Throughput: one item per cycle while the output is not stalled. Three
//   lanes, one per axis, each run a restoring divider that retires one
//   quotient bit per pipeline stage.
// Pipeline: the accepting edge loads the offset and range check stage,
//   DEPTH divider stages follow, then one output register.
// Stall: each pipeline stage moves when it is empty or its successor
//   moves, so bubbles close up; with every stage full and the output
//   stalled, in_stall rises.
// Reset: clears all valid bits and the config registers (origin and
//   extent zero, so every cell reads 0 until configured).
// ----------------------------------------------------------------------------
`include "point_to_morton_code_top_defines.svh"

module point_to_morton_code_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [31:0]          point_x,
    input  logic signed [31:0]          point_y,
    input  logic signed [31:0]          point_z,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [62:0]                 morton_code,
    output logic [20:0]                 cell_x,
    output logic [20:0]                 cell_y,
    output logic [20:0]                 cell_z,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [31:0]                 cfg_data
);

    // configuration registers
    logic [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic [31:0] ext_x_reg, ext_y_reg, ext_z_reg;

    // pipeline control
    logic [mc_pkg::STAGES-1:0] vld_reg;
    logic [mc_pkg::STAGES-1:0] vld_next;
    logic [mc_pkg::STAGES:0]   ready;
    logic                      out_vld_reg;
    logic                      out_vld_next;
    mc_pkg::mrg_ctrl_t         mrg_ctrl;

    logic [mc_pkg::DEPTH-1:0]  lane_x, lane_y, lane_z;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            ext_x_reg <= '0;
            ext_y_reg <= '0;
            ext_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mc_pkg::CFG_ORIGIN_X: org_x_reg <= cfg_data;
                mc_pkg::CFG_ORIGIN_Y: org_y_reg <= cfg_data;
                mc_pkg::CFG_ORIGIN_Z: org_z_reg <= cfg_data;
                mc_pkg::CFG_EXTENT_X: ext_x_reg <= cfg_data;
                mc_pkg::CFG_EXTENT_Y: ext_y_reg <= cfg_data;
                mc_pkg::CFG_EXTENT_Z: ext_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        ready[mc_pkg::STAGES] = !out_vld_reg || !out_stall;
        for (int i = mc_pkg::STAGES - 1; i >= 0; i--)
        begin
            ready[i] = !vld_reg[i] || ready[i+1];
        end
        vld_next = vld_reg;
        if (ready[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < mc_pkg::STAGES; i++)
        begin
            if (ready[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
        out_vld_next  = ready[mc_pkg::STAGES] ? vld_reg[mc_pkg::STAGES-1] : out_vld_reg;
        mrg_ctrl.load = ready[mc_pkg::STAGES];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = out_vld_reg;

    mc_lane u_lane_x (
        .clk      (clk),
        .point    (point_x),
        .origin   (org_x_reg),
        .extent   (ext_x_reg),
        .en       (ready[mc_pkg::STAGES-1:0]),
        .grid_pos (lane_x)
    );

    mc_lane u_lane_y (
        .clk      (clk),
        .point    (point_y),
        .origin   (org_y_reg),
        .extent   (ext_y_reg),
        .en       (ready[mc_pkg::STAGES-1:0]),
        .grid_pos (lane_y)
    );

    mc_lane u_lane_z (
        .clk      (clk),
        .point    (point_z),
        .origin   (org_z_reg),
        .extent   (ext_z_reg),
        .en       (ready[mc_pkg::STAGES-1:0]),
        .grid_pos (lane_z)
    );

    mc_merge u_merge (
        .clk         (clk),
        .ctrl        (mrg_ctrl),
        .lane_x      (lane_x),
        .lane_y      (lane_y),
        .lane_z      (lane_z),
        .morton_code (morton_code),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_z      (cell_z)
    );

    // an empty output register never blocks the input
    `MC_ASSERT(a_no_false_stall, !out_vld_reg |-> !in_stall)
    // a taken result with nothing behind it leaves the output empty
    `MC_ASSERT_NEXT(a_drain, out_vld_reg && !out_stall && !vld_reg[mc_pkg::STAGES-1], !out_vld_reg)
    // top code bit tracks the top x cell bit
    `MC_ASSERT(a_code_msb, out_vld_reg |-> (morton_code[62] == cell_x[20]))

endmodule

// File: rtl/mc_lane.sv
// ----------------------------------------------------------------------------
// mc_lane
// One axis: offset from origin, range check, then a restoring divider with
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module mc_lane (
    input  logic                        clk,
    input  logic [mc_pkg::COORD_W-1:0]  point,
    input  logic [mc_pkg::COORD_W-1:0]  origin,
    input  logic [mc_pkg::COORD_W-1:0]  extent,
    input  logic [mc_pkg::STAGES-1:0]   en,
    output logic [mc_pkg::DEPTH-1:0]    grid_pos
);

    logic signed [mc_pkg::COORD_W:0] diff;
    logic                            zero_c;
    logic                            sat_c;

    logic [mc_pkg::COORD_W-1:0] rem_reg  [0:mc_pkg::DEPTH-1];
    logic [mc_pkg::DEPTH-1:0]   quo_reg  [0:mc_pkg::DEPTH];
    logic                       zero_reg [0:mc_pkg::DEPTH];
    logic                       sat_reg  [0:mc_pkg::DEPTH];

    assign diff   = $signed({point[mc_pkg::COORD_W-1], point})
                  - $signed({origin[mc_pkg::COORD_W-1], origin});
    assign zero_c = (extent == '0) || diff[mc_pkg::COORD_W] || (diff == '0);
    // quotient reaches 2^DEPTH exactly when diff >= extent
    assign sat_c  = !zero_c && (diff[mc_pkg::COORD_W-1:0] >= extent);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]  <= diff[mc_pkg::COORD_W-1:0];
            quo_reg[0]  <= '0;
            zero_reg[0] <= zero_c;
            sat_reg[0]  <= sat_c;
        end
    end

    // remainder stays below extent for in-range points; the 32-bit remainder doubled fits 33 bits
    for (genvar k = 1; k <= mc_pkg::DEPTH; k++)
    begin : g_div
        logic [mc_pkg::COORD_W:0] dbl;
        logic                     ge;
        logic [mc_pkg::DEPTH:0]   qs;

        assign dbl = {rem_reg[k-1], 1'b0};
        assign ge  = (dbl >= {1'b0, extent});
        assign qs  = {quo_reg[k-1], ge};

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                quo_reg[k]  <= qs[mc_pkg::DEPTH-1:0];
                zero_reg[k] <= zero_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
            end
        end

        if (k < mc_pkg::DEPTH)
        begin : g_rem
            logic [mc_pkg::COORD_W:0] sub;

            assign sub = dbl - {1'b0, extent};

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k] <= ge ? sub[mc_pkg::COORD_W-1:0]
                                     : dbl[mc_pkg::COORD_W-1:0];
                end
            end
        end
    end

    assign grid_pos = zero_reg[mc_pkg::DEPTH] ? '0 :
                      sat_reg[mc_pkg::DEPTH]  ? mc_pkg::CELL_MAX :
                                                quo_reg[mc_pkg::DEPTH];

endmodule

// File: rtl/mc_merge.sv
// ----------------------------------------------------------------------------
// mc_merge
// Interleaves the three lane cells into the Morton code; output register.
// ----------------------------------------------------------------------------
module mc_merge (
    input  logic                       clk,
    input  mc_pkg::mrg_ctrl_t          ctrl,
    input  logic [mc_pkg::DEPTH-1:0]   lane_x,
    input  logic [mc_pkg::DEPTH-1:0]   lane_y,
    input  logic [mc_pkg::DEPTH-1:0]   lane_z,
    output logic [mc_pkg::CODE_W-1:0]  morton_code,
    output logic [mc_pkg::DEPTH-1:0]   cell_x,
    output logic [mc_pkg::DEPTH-1:0]   cell_y,
    output logic [mc_pkg::DEPTH-1:0]   cell_z
);

    logic [mc_pkg::CODE_W-1:0] code_reg;
    logic [mc_pkg::DEPTH-1:0]  cx_reg;
    logic [mc_pkg::DEPTH-1:0]  cy_reg;
    logic [mc_pkg::DEPTH-1:0]  cz_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            code_reg <= mc_pkg::interleave(lane_x, lane_y, lane_z);
            cx_reg   <= lane_x;
            cy_reg   <= lane_y;
            cz_reg   <= lane_z;
        end
    end

    assign morton_code = code_reg;
    assign cell_x      = cx_reg;
    assign cell_y      = cy_reg;
    assign cell_z      = cz_reg;

endmodule
